@@ hdl/efsd_pkg.sv @@
// Package for the earliest-free server dispatch block: fixed field widths.
`default_nettype none
package efsd_pkg;
	localparam int CFG_W      = 4;
	localparam int SVC_W      = 16;
	localparam int WIN_OUT_W  = 3;
	localparam int TIME_OUT_W = 48;
	localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(1);
endpackage
`default_nettype wire

@@ hdl/earliest_free_server_dispatch.sv @@
// Earliest-free server dispatch: picks a server per job and reports start and wait times.
//
// Input channel: service_time and last_customer with in_valid/in_stall; an item is taken
// at a rising edge with in_valid high and in_stall low. Output channel: window_index,
// start_time, wait_time, cum_wait, batch_done and overflow with out_valid/out_stall.
// Configuration: cfg_we writes cfg_data into the active server count (0 acts as 1,
// values above MAX_WINDOWS act as MAX_WINDOWS). Write it only while the block is idle.
// An item lands in an input register at its accepting edge; its result is registered
// in the output register when the item advances, and is offered from there. One item
// is taken per cycle, sustained while out_stall is low: the per-item minimum search
// over the server free times, the start-time select and the saturating adds are
// combinational from the free-time registers. A stalled result holds in the output
// register while the next item waits in the input register; in_stall rises only when both are full.
// The job arrival time is its position in the batch. After the item flagged
// last_customer, the free times, arrival count, wait sum and overflow flag return to
// zero; the server count is kept. Reset clears all of this and sets the count to one.
`default_nettype none
module earliest_free_server_dispatch #(
	parameter int MAX_WINDOWS = 8,
	parameter int TIME_BITS   = 48
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [efsd_pkg::CFG_W-1:0]         cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [efsd_pkg::SVC_W-1:0]         service_time,
	input  wire logic                               last_customer,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [efsd_pkg::WIN_OUT_W-1:0]          window_index,
	output logic [efsd_pkg::TIME_OUT_W-1:0]         start_time,
	output logic [efsd_pkg::TIME_OUT_W-1:0]         wait_time,
	output logic [efsd_pkg::TIME_OUT_W-1:0]         cum_wait,
	output logic                                    batch_done,
	output logic                                    overflow
);
	localparam int IDX_W  = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
	localparam int LEAVES = 1 << IDX_W;
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	logic [efsd_pkg::CFG_W-1:0] active_q;
	logic [TIME_BITS-1:0]       free_q [MAX_WINDOWS];
	logic [TIME_BITS-1:0]       arrival_q;
	logic [TIME_BITS-1:0]       wait_sum_q;
	logic                       ovf_q;

	logic                       valid_s1;
	logic [efsd_pkg::SVC_W-1:0] svc_s1;
	logic                       last_s1;

	logic                       valid_s2;
	logic [IDX_W-1:0]           win_s2;
	logic [TIME_BITS-1:0]       start_s2;
	logic [TIME_BITS-1:0]       wait_s2;
	logic [TIME_BITS-1:0]       sum_s2;
	logic                       done_s2;
	logic                       ovf_s2;

	logic                       adv;

	// min tree, heap order, leaves at LEAVES .. 2*LEAVES-1
	logic                       node_v [1:2*LEAVES-1];
	logic [TIME_BITS-1:0]       node_t [1:2*LEAVES-1];
	logic [IDX_W-1:0]           node_i [1:2*LEAVES-1];

	logic [IDX_W-1:0]           best;
	logic [TIME_BITS-1:0]       best_free;
	logic [TIME_BITS-1:0]       start_c;
	logic [TIME_BITS-1:0]       wait_c;
	logic [TIME_BITS:0]         sum_w;
	logic [TIME_BITS:0]         free_w;
	logic [TIME_BITS:0]         arr_w;
	logic [TIME_BITS-1:0]       sum_c;
	logic [TIME_BITS-1:0]       free_c;
	logic [TIME_BITS-1:0]       arr_c;
	logic                       ovf_c;

	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_comb begin
		for (int k = 1; k < 2*LEAVES; k++) begin
			node_v[k] = 1'b0;
			node_t[k] = '0;
			node_i[k] = '0;
		end
		for (int j = 0; j < MAX_WINDOWS; j++) begin
			node_v[LEAVES+j] = (j == 0) || (int'(active_q) > j);
			node_t[LEAVES+j] = free_q[j];
			node_i[LEAVES+j] = IDX_W'(j);
		end
		for (int k = LEAVES-1; k >= 1; k--) begin
			if (node_v[2*k+1] && (!node_v[2*k] || node_t[2*k+1] < node_t[2*k])) begin
				node_v[k] = node_v[2*k+1];
				node_t[k] = node_t[2*k+1];
				node_i[k] = node_i[2*k+1];
			end else begin
				node_v[k] = node_v[2*k];
				node_t[k] = node_t[2*k];
				node_i[k] = node_i[2*k];
			end
		end
	end

	assign best      = node_i[1];
	assign best_free = node_t[1];
	assign start_c   = (best_free > arrival_q) ? best_free : arrival_q;
	assign wait_c    = start_c - arrival_q;

	assign sum_w  = {1'b0, wait_sum_q} + {1'b0, wait_c};
	assign free_w = {1'b0, start_c} + (TIME_BITS+1)'(svc_s1);
	assign arr_w  = {1'b0, arrival_q} + (TIME_BITS+1)'(1);

	assign sum_c  = sum_w[TIME_BITS]  ? TIME_MAX : sum_w[TIME_BITS-1:0];
	assign free_c = free_w[TIME_BITS] ? TIME_MAX : free_w[TIME_BITS-1:0];
	assign arr_c  = arr_w[TIME_BITS]  ? TIME_MAX : arr_w[TIME_BITS-1:0];
	assign ovf_c  = ovf_q || sum_w[TIME_BITS] || free_w[TIME_BITS] || arr_w[TIME_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= efsd_pkg::ACTIVE_RESET;
		end else if (cfg_we) begin
			active_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_WINDOWS; j++) free_q[j] <= '0;
			arrival_q  <= '0;
			wait_sum_q <= '0;
			ovf_q      <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				for (int j = 0; j < MAX_WINDOWS; j++) free_q[j] <= '0;
				arrival_q  <= '0;
				wait_sum_q <= '0;
				ovf_q      <= 1'b0;
			end else begin
				for (int j = 0; j < MAX_WINDOWS; j++) begin
					if (best == IDX_W'(j)) free_q[j] <= free_c;
				end
				arrival_q  <= arr_c;
				wait_sum_q <= sum_c;
				ovf_q      <= ovf_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) valid_s1 <= in_valid;
			if (adv) valid_s2 <= 1'b1;
			else if (!out_stall) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			svc_s1  <= service_time;
			last_s1 <= last_customer;
		end
		if (adv) begin
			win_s2   <= best;
			start_s2 <= start_c;
			wait_s2  <= wait_c;
			sum_s2   <= sum_c;
			done_s2  <= last_s1;
			ovf_s2   <= ovf_c;
		end
	end

	assign out_valid    = valid_s2;
	assign window_index = efsd_pkg::WIN_OUT_W'(win_s2);
	assign start_time   = efsd_pkg::TIME_OUT_W'(start_s2);
	assign wait_time    = efsd_pkg::TIME_OUT_W'(wait_s2);
	assign cum_wait     = efsd_pkg::TIME_OUT_W'(sum_s2);
	assign batch_done   = done_s2;
	assign overflow     = ovf_s2;

	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("result lost on advance");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_stall && !adv) |=> !valid_s2)
		else $error("taken result offered again");

	a_batch_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (arrival_q == '0 && wait_sum_q == '0 && !ovf_q))
		else $error("batch state not cleared after last item");
endmodule
`default_nettype wire
